// ===== rtl/blm_pkg.sv =====
// blm_pkg: shared widths, command and register codes, and structs for the
// battery low monitor. No dependencies.
package blm_pkg;

  // stream payload widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int SAMPLE_W    = 12;
  localparam int MV_W        = 16;
  localparam int AVG_W       = 24;
  localparam int FRAC_W      = 8;

  // divider and scaling
  localparam int QUO_W     = 24;
  localparam int MVQ_W     = 12;
  localparam int PROD_W    = MVQ_W + 16;
  localparam int SCALE_MV  = 3300;
  localparam int ADC_FULL  = 4095;
  localparam int HYST_DEN  = 20;
  localparam int HYST_NUM  = 21;
  localparam int V20_W     = AVG_W + 5;
  localparam int T21_W     = 16 + 5;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIP    = 2'd3;

  localparam logic [15:0] RST_LOW_THR = 16'd3600;
  localparam logic [15:0] RST_GAIN    = 16'd4096;
  localparam logic [15:0] RST_PERIOD  = 16'd1000;
  localparam logic [7:0]  RST_TRIP    = 8'd10;

  // commands from front to back
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] CMD_PASS   = 2'd0;
  localparam logic [KIND_W-1:0] CMD_ABSORB = 2'd1;
  localparam logic [KIND_W-1:0] CMD_TICK   = 2'd2;

  typedef struct packed {
    logic [15:0] low_thr;
    logic [15:0] gain;
    logic [15:0] period;
    logic [7:0]  trip;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic long_mode;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ===== rtl/blm_front.sv =====
// blm_front: accepts input transactions, sums samples into blocks and
// turns each item into a command for the back end. Depends on blm_pkg.
module blm_front import blm_pkg::*; #(
  parameter int SAMPLES_PER_BLOCK = 16,
  parameter int SUM_W             = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output logic [KIND_W-1:0]     cmd_kind,
  output logic [SUM_W-1:0]      cmd_sum
);

  localparam int FILL_W = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(SAMPLES_PER_BLOCK - 1);

  logic [SUM_W-1:0]  sum_r;
  logic [FILL_W-1:0] fill_r;
  logic [SUM_W-1:0]  sum_add;
  logic              last;
  logic              accept;

  assign in_tready = cmd_ready;
  assign cmd_valid = in_tvalid;
  assign accept    = in_tvalid && cmd_ready;
  assign sum_add   = sum_r + SUM_W'(in_tdata[SAMPLE_W-1:0]);
  assign last      = (fill_r == FILL_LAST);
  assign cmd_sum   = sum_add;

  always_comb begin
    priority if (in_tuser) begin
      cmd_kind = CMD_TICK;
    end else if (last) begin
      cmd_kind = CMD_ABSORB;
    end else begin
      cmd_kind = CMD_PASS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      fill_r <= '0;
    end else if (accept && !in_tuser) begin
      if (last) begin
        sum_r  <= '0;
        fill_r <= '0;
      end else begin
        sum_r  <= sum_add;
        fill_r <= fill_r + FILL_W'(1);
      end
    end
  end

endmodule

// ===== rtl/blm_queue.sv =====
// blm_queue: two-entry command queue between front and back end.
// Depends on blm_pkg only through the importing modules.
module blm_queue #(
  parameter int WIDTH = 18
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             push;
  logic             pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/blm_div.sv =====
// blm_div: constant divider by reciprocal multiplication; short mode divides
// by the block full scale, long mode by the smoothing window. Depends on blm_pkg.
module blm_div import blm_pkg::*; #(
  parameter int SAMPLES_PER_BLOCK = 16,
  parameter int SMOOTH_WINDOW     = 16,
  parameter int DIV_W             = 16,
  parameter int NUM_W             = 28
) (
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl,
  input  logic [NUM_W-1:0] num,
  output div_sts_t         sts,
  output logic [QUO_W-1:0] quo
);

  localparam int OPA_W  = (NUM_W > AVG_W) ? NUM_W : AVG_W;
  localparam int RCP_W  = OPA_W + 1;
  localparam int PRD_W  = OPA_W + RCP_W;
  localparam int WIN_L  = $clog2(SMOOTH_WINDOW);
  // shift = operand bits + divisor bits keeps floor(n * m >> shift) exact
  localparam int MV_SH  = NUM_W + DIV_W;
  localparam int WIN_SH = AVG_W + WIN_L;
  localparam longint MV_D  = longint'(ADC_FULL) * longint'(SAMPLES_PER_BLOCK);
  localparam longint WIN_D = longint'(SMOOTH_WINDOW);
  localparam logic [RCP_W-1:0] MV_RCP  =
    RCP_W'(((longint'(1) << MV_SH) + MV_D - 1) / MV_D);
  localparam logic [RCP_W-1:0] WIN_RCP =
    RCP_W'(((longint'(1) << WIN_SH) + WIN_D - 1) / WIN_D);

  logic [OPA_W-1:0] opa_r;
  logic [RCP_W-1:0] rcp_r;
  logic             long_r;
  logic [PRD_W-1:0] prod_r;
  logic             busy_r;
  logic             done_r;

  // long_r only changes on start, so it still selects the shift at done
  assign quo = long_r ? QUO_W'(prod_r >> WIN_SH) : QUO_W'(prod_r >> MV_SH);
  assign sts = '{busy: busy_r, done: done_r};

  // operand stage, then product stage
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      opa_r  <= OPA_W'(num);
      rcp_r  <= ctl.long_mode ? WIN_RCP : MV_RCP;
      long_r <= ctl.long_mode;
    end
    if (busy_r) begin
      prod_r <= PRD_W'(opa_r) * PRD_W'(rcp_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= ctl.start;
      done_r <= busy_r;
    end
  end

endmodule

// ===== rtl/blm_back.sv =====
// blm_back: executes commands: block scaling, smoothing, tick counting and
// debounced low detection; drives the result register. Depends on blm_pkg.
module blm_back import blm_pkg::*; #(
  parameter int SUM_W             = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  logic [KIND_W-1:0]      cmd_kind,
  input  logic [SUM_W-1:0]       cmd_sum,
  output div_ctl_t               div_ctl,
  output logic [SUM_W+MVQ_W-1:0] div_num,
  input  div_sts_t               div_sts,
  input  logic [QUO_W-1:0]       div_quo,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser
);

  localparam int NUM_W = SUM_W + MVQ_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MV_GO = 4'd1;
  localparam logic [3:0] ST_MV_WT = 4'd2;
  localparam logic [3:0] ST_GAIN  = 4'd3;
  localparam logic [3:0] ST_LOAD  = 4'd4;
  localparam logic [3:0] ST_V_GO  = 4'd5;
  localparam logic [3:0] ST_V_WT  = 4'd6;
  localparam logic [3:0] ST_X_GO  = 4'd7;
  localparam logic [3:0] ST_X_WT  = 4'd8;
  localparam logic [3:0] ST_TICK  = 4'd9;
  localparam logic [3:0] ST_CHK   = 4'd10;
  localparam logic [3:0] ST_DEB   = 4'd11;
  localparam logic [3:0] ST_OUT   = 4'd12;

  logic [3:0]       state_r;
  logic [3:0]       state_nxt;
  logic [NUM_W-1:0] p_r;
  logic [MVQ_W-1:0] mv_r;
  logic [PROD_W-1:0] prod_r;
  logic [AVG_W-1:0] xq_r;
  logic [AVG_W-1:0] qv_r;
  logic [AVG_W-1:0] v_r;
  logic             started_r;
  logic [15:0]      ticks_r;
  logic [7:0]       cnt_r;
  logic             low_r;
  logic             event_r;
  logic [V20_W-1:0] v20_r;
  logic [T21_W-1:0] t21_r;
  logic             out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic             out_user_r;

  logic             pop;
  logic             out_load;
  logic [15:0]      ticks_inc;
  logic             check_due;
  logic [AVG_W-1:0] xq;
  logic             below;
  logic             above;
  logic [7:0]       cnt_inc;
  logic [7:0]       cnt_dec;

  assign cmd_ready  = (state_r == ST_IDLE);
  assign pop        = cmd_valid && cmd_ready;
  assign out_load   = (state_r == ST_OUT) && (!out_valid_r || out_tready);
  assign ticks_inc  = (ticks_r == 16'hFFFF) ? ticks_r : ticks_r + 16'd1;
  assign check_due  = (ticks_inc >= cfg.period);
  // 12-bit mV times Q4.12 gain shifted by 12 always fits 16 bits
  assign xq         = {prod_r[PROD_W-1:MVQ_W], {FRAC_W{1'b0}}};
  assign below      = (v_r < {cfg.low_thr, {FRAC_W{1'b0}}});
  assign above      = (v20_r > {t21_r, {FRAC_W{1'b0}}});
  assign cnt_inc    = (cnt_r == 8'hFF) ? cnt_r : cnt_r + 8'd1;
  assign cnt_dec    = (cnt_r == 8'h00) ? cnt_r : cnt_r - 8'd1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    state_nxt = state_r;
    div_ctl   = '{start: 1'b0, long_mode: 1'b0};
    div_num   = p_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          unique case (cmd_kind)
            CMD_ABSORB: state_nxt = ST_MV_GO;
            CMD_TICK:   state_nxt = ST_TICK;
            default:    state_nxt = ST_OUT;
          endcase
        end
      end
      ST_MV_GO: begin
        div_ctl   = '{start: 1'b1, long_mode: 1'b0};
        state_nxt = ST_MV_WT;
      end
      ST_MV_WT: begin
        if (div_sts.done) begin
          state_nxt = ST_GAIN;
        end
      end
      ST_GAIN: state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = started_r ? ST_V_GO : ST_OUT;
      ST_V_GO: begin
        div_ctl   = '{start: 1'b1, long_mode: 1'b1};
        div_num   = NUM_W'(v_r);
        state_nxt = ST_V_WT;
      end
      ST_V_WT: begin
        if (div_sts.done) begin
          state_nxt = ST_X_GO;
        end
      end
      ST_X_GO: begin
        div_ctl   = '{start: 1'b1, long_mode: 1'b1};
        div_num   = NUM_W'(xq_r);
        state_nxt = ST_X_WT;
      end
      ST_X_WT: begin
        if (div_sts.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_TICK: state_nxt = check_due ? ST_CHK : ST_OUT;
      ST_CHK:  state_nxt = ST_DEB;
      ST_DEB:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    if (pop) begin
      p_r <= NUM_W'(cmd_sum) * NUM_W'(SCALE_MV);
    end
    if (state_r == ST_MV_WT && div_sts.done) begin
      mv_r <= div_quo[MVQ_W-1:0];
    end
    if (state_r == ST_GAIN) begin
      prod_r <= PROD_W'(mv_r) * PROD_W'(cfg.gain);
    end
    if (state_r == ST_LOAD) begin
      xq_r <= xq;
    end
    if (state_r == ST_V_WT && div_sts.done) begin
      qv_r <= div_quo;
    end
    if (state_r == ST_CHK) begin
      v20_r <= V20_W'(v_r) * V20_W'(HYST_DEN);
      t21_r <= T21_W'(cfg.low_thr) * T21_W'(HYST_NUM);
    end
    if (out_load) begin
      out_data_r <= OUT_TDATA_W'({event_r, low_r, v_r[AVG_W-1:FRAC_W]});
      out_user_r <= started_r;
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      v_r         <= '0;
      started_r   <= 1'b0;
      ticks_r     <= '0;
      cnt_r       <= '0;
      low_r       <= 1'b0;
      event_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        event_r <= 1'b0;
      end
      if (state_r == ST_LOAD && !started_r) begin
        v_r       <= xq;
        started_r <= 1'b1;
      end
      if (state_r == ST_X_WT && div_sts.done) begin
        v_r <= v_r - qv_r + div_quo;
      end
      if (state_r == ST_TICK) begin
        ticks_r <= check_due ? 16'd0 : ticks_inc;
      end
      if (state_r == ST_DEB) begin
        if (!low_r) begin
          if (below) begin
            cnt_r <= cnt_inc;
            if (cnt_inc >= cfg.trip) begin
              low_r   <= 1'b1;
              event_r <= 1'b1;
            end
          end
        end else if (above) begin
          cnt_r <= cnt_dec;
          if (cnt_dec == 8'h00) begin
            low_r <= 1'b0;
          end
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/battery_low_monitor.sv =====
// battery_low_monitor: a sample that closes a block runs the mV division by
// reciprocal multiply; later blocks add two smoothing divisions, three in all.
// The back end takes a new transaction only once the previous result has been
// loaded into the result register; the two-entry queue lets the front take up
// to two transactions ahead. Synchronous active-low reset clears the control
// state and restores the configuration reset values; datapath registers are not reset.
module battery_low_monitor import blm_pkg::*; #(
  parameter int SAMPLES_PER_BLOCK = 16,
  parameter int SMOOTH_WINDOW     = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [11:0] sample, [15:12] zero
  input  logic                   in_tuser,   // [0] req_type, 1 = tick
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [15:0] battery_mv, [16] low_flag,
                                             // [17] low_event, [23:18] zero
  output logic                   out_tuser,  // [0] average_valid
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // block sum must hold SAMPLES_PER_BLOCK full-scale samples
  localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES_PER_BLOCK);
  localparam int NUM_W = SUM_W + MVQ_W;
  localparam int Q_W   = KIND_W + SUM_W;

  cfg_t              cfg_r;
  logic              f_valid;
  logic              f_ready;
  logic [KIND_W-1:0] f_kind;
  logic [SUM_W-1:0]  f_sum;
  logic              q_valid;
  logic              q_ready;
  logic [Q_W-1:0]    q_data;
  div_ctl_t          div_ctl;
  div_sts_t          div_sts;
  logic [NUM_W-1:0]  div_num;
  logic [QUO_W-1:0]  div_quo;

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{low_thr: RST_LOW_THR, gain: RST_GAIN,
                 period: RST_PERIOD, trip: RST_TRIP};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LOW_THR: cfg_r.low_thr <= cfg_data;
        REG_GAIN:    cfg_r.gain    <= cfg_data;
        REG_PERIOD:  cfg_r.period  <= cfg_data;
        REG_TRIP:    cfg_r.trip    <= cfg_data[7:0];
        default:     cfg_r         <= cfg_r;
      endcase
    end
  end

  // front: block accumulation and item classification
  blm_front #(
    .SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK),
    .SUM_W            (SUM_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cmd_valid(f_valid),
    .cmd_ready(f_ready),
    .cmd_kind (f_kind),
    .cmd_sum  (f_sum)
  );

  // command queue decouples front from back
  blm_queue #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(f_valid),
    .wr_ready(f_ready),
    .wr_data ({f_kind, f_sum}),
    .rd_valid(q_valid),
    .rd_ready(q_ready),
    .rd_data (q_data)
  );

  // shared reciprocal divider for mV scaling and smoothing
  blm_div #(
    .SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK),
    .SMOOTH_WINDOW    (SMOOTH_WINDOW),
    .DIV_W            (SUM_W),
    .NUM_W            (NUM_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (div_ctl),
    .num  (div_num),
    .sts  (div_sts),
    .quo  (div_quo)
  );

  // back: arithmetic, debounce and result register
  blm_back #(
    .SUM_W            (SUM_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd_kind  (q_data[Q_W-1:SUM_W]),
    .cmd_sum   (q_data[SUM_W-1:0]),
    .div_ctl   (div_ctl),
    .div_num   (div_num),
    .div_sts   (div_sts),
    .div_quo   (div_quo),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

// ===== rtl/blm_checker.sv =====
// blm_checker: port-level assertions for battery_low_monitor, bound to the
// top level. Depends on blm_pkg.
module blm_checker import blm_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // reset empties the result register
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // an event only comes with the flag raised
  a_event_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17] |-> out_tdata[16])
    else $error("low event without low flag");

  // a nonzero voltage needs a loaded average
  a_mv_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[15:0] != 16'd0) |-> out_tuser)
    else $error("voltage reported before average loaded");

endmodule

bind battery_low_monitor blm_checker u_blm_checker (.*);

// ===== tb/sv/blm_result_checker.sv =====
// blm_result_checker: watches the sample, result and configuration channels of the
// battery low monitor, predicts every reading and compares it field by field.
// Depends on blm_pkg for widths, register codes and scaling constants.
module blm_result_checker import blm_pkg::*; #(
  parameter int SAMPLES_PER_BLOCK = 16,
  parameter int SMOOTH_WINDOW     = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tuser,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending
);

  typedef struct packed {
    logic [15:0] mv;
    logic        avg_valid;
    logic        low_flag;
    logic        low_event;
  } reading_t;

  reading_t expected_readings[$];

  // shadow configuration
  logic [15:0] thr_q;
  logic [15:0] gain_q;
  logic [15:0] period_q;
  logic [7:0]  trip_q;

  // shadow monitor state
  logic [31:0] blk_sum;
  int          blk_cnt;
  logic [23:0] avg_q;
  logic        avg_live;
  logic [15:0] tick_cnt;
  logic [7:0]  deb_cnt;
  logic        low_q;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // fold one closed block into the Q16.8 average
  task automatic absorb_block();
    logic [31:0] mv;
    logic [47:0] prod;
    logic [35:0] x;
    logic [23:0] xq;
    mv   = (blk_sum * SCALE_MV) / (ADC_FULL * SAMPLES_PER_BLOCK);
    prod = 48'(mv) * 48'(gain_q);
    x    = 36'(prod >> 12);
    xq   = (x > 36'd65535) ? 24'hFFFF00 : {x[15:0], 8'h00};
    if (avg_live) begin
      avg_q = 24'(avg_q - avg_q / SMOOTH_WINDOW + xq / SMOOTH_WINDOW);
    end else begin
      avg_q    = xq;
      avg_live = 1'b1;
    end
  endtask

  // debounced low detection with hysteresis; returns the raise event
  function automatic logic run_low_check();
    logic below;
    logic above;
    below = {8'd0, avg_q} < {thr_q, 8'd0};
    above = (40'(avg_q) * HYST_DEN) > (40'(thr_q) * HYST_NUM * 256);
    run_low_check = 1'b0;
    if (!low_q) begin
      if (below) begin
        if (deb_cnt != 8'hFF) deb_cnt = deb_cnt + 8'd1;
        if (deb_cnt >= trip_q) begin
          low_q = 1'b1;
          run_low_check = 1'b1;
        end
      end
    end else if (above) begin
      if (deb_cnt != 8'd0) deb_cnt = deb_cnt - 8'd1;
      if (deb_cnt == 8'd0) low_q = 1'b0;
    end
  endfunction

  task automatic advance_monitor(input logic is_tick, input logic [SAMPLE_W-1:0] smp,
                                 output reading_t r);
    logic evt;
    evt = 1'b0;
    if (!is_tick) begin
      blk_sum = blk_sum + 32'(smp);
      blk_cnt++;
      if (blk_cnt >= SAMPLES_PER_BLOCK) begin
        absorb_block();
        blk_sum = '0;
        blk_cnt = 0;
      end
    end else begin
      if (tick_cnt != 16'hFFFF) tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= period_q) begin
        tick_cnt = '0;
        evt = run_low_check();
      end
    end
    r.mv        = avg_q[23:8];
    r.avg_valid = avg_live;
    r.low_flag  = low_q;
    r.low_event = evt;
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    reading_t r;
    if (!rst_n) begin
      thr_q    = RST_LOW_THR;
      gain_q   = RST_GAIN;
      period_q = RST_PERIOD;
      trip_q   = RST_TRIP;
      blk_sum  = '0;
      blk_cnt  = 0;
      avg_q    = '0;
      avg_live = 1'b0;
      tick_cnt = '0;
      deb_cnt  = '0;
      low_q    = 1'b0;
      expected_readings.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOW_THR: thr_q    = cfg_data;
          REG_GAIN:    gain_q   = cfg_data;
          REG_PERIOD:  period_q = cfg_data;
          REG_TRIP:    trip_q   = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        advance_monitor(in_tuser, in_tdata[SAMPLE_W-1:0], r);
        expected_readings.push_back(r);
      end
      if (out_tvalid && out_tready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result, actual battery_mv %0d", $time, out_tdata[15:0]);
          fail_count++;
        end else begin
          r = expected_readings.pop_front();
          check_field("battery_mv", r.mv, out_tdata[15:0]);
          check_field("average_valid", r.avg_valid, out_tuser);
          check_field("low_flag", r.low_flag, out_tdata[16]);
          check_field("low_event", r.low_event, out_tdata[17]);
        end
      end
    end
    pending = expected_readings.size();
  end

endmodule

// ===== tb/sv/tb_battery_low_monitor.sv =====
// tb_battery_low_monitor: drives samples, ticks and register writes into the
// battery low monitor and gives the verdict. Depends on blm_pkg, the block and
// blm_result_checker, which does all prediction and comparison.
module tb_battery_low_monitor import blm_pkg::*;;

  localparam int SPB  = 16;
  localparam int SWIN = 16;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [11:0] sample, [15:12] zero
  logic                   in_tuser = 1'b0; // [0] req_type, 1 = tick
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [15:0] battery_mv, [16] low_flag,
                                           // [17] low_event, [23:18] zero
  logic                   out_tuser;       // [0] average_valid
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int fail_count;
  int pending;

  // idling knobs, percent of cycles
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic rx_hold = 1'b0;   // long receiver hold-off for back-pressure
  int   level = 2048;     // drifting converter level for well-formed samples

  battery_low_monitor #(
    .SAMPLES_PER_BLOCK(SPB),
    .SMOOTH_WINDOW    (SWIN)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  blm_result_checker #(
    .SAMPLES_PER_BLOCK(SPB),
    .SMOOTH_WINDOW    (SWIN)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always #6 clk = ~clk;

  // receiver: random stalls, plus the long hold-off
  always @(negedge clk) begin
    out_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // safety net against a hung block
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // one input transaction; entered and left at a falling edge
  task automatic send_item(input logic is_tick, input logic [SAMPLE_W-1:0] smp);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= is_tick;
    in_tdata  <= {4'b0000, smp};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // stop offering and wait until every reading has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // write all four registers, only while the block is idle
  task automatic set_config(input logic [15:0] thr, input logic [15:0] gain,
                            input logic [15:0] period, input logic [7:0] trip);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{REG_LOW_THR, REG_GAIN, REG_PERIOD, REG_TRIP};
    // upper byte of the trip write is don't-care, so randomize it
    val = '{thr, gain, period, {8'($urandom_range(255)), trip}};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
  endtask

  // mostly a slowly drifting level with sudden jumps, some pure noise
  task automatic run_random(input int count, input int tick_pct);
    logic [SAMPLE_W-1:0] smp;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < tick_pct) begin
        send_item(1'b1, 12'($urandom_range(4095)));
      end else begin
        if ($urandom_range(99) < 5) level = $urandom_range(4095);
        level = level + $urandom_range(200) - 100;
        if (level < 0) level = 0;
        if (level > 4095) level = 4095;
        smp = ($urandom_range(99) < 10) ? 12'($urandom_range(4095)) : 12'(level);
        send_item(1'b0, smp);
      end
    end
  endtask

  // random configuration with the threshold inside the reachable mV span
  task automatic random_config();
    logic [15:0] gain;
    int          top_mv;
    gain   = 16'($urandom_range(1024, 16384));
    top_mv = (3300 * int'(gain)) / 4096;
    set_config(16'($urandom_range(top_mv)), gain, 16'($urandom_range(4)),
               8'($urandom_range(1, 6)));
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, sender 24% idle, receiver 68% idle
    set_idling(24, 68);
    // reset config: long check period, so ticks only count
    send_item(1'b1, 12'hFFF);
    send_item(1'b1, 12'h000);
    send_item(1'b0, 12'h000);
    send_item(1'b0, 12'hFFF);
    send_item(1'b0, 12'hAAA);
    send_item(1'b0, 12'h555);
    drain();
    // zero period and zero trip count: every tick checks, and the check
    // before any block sees a zero average and raises the flag at once
    set_config(RST_LOW_THR, RST_GAIN, 16'd0, 8'd0);
    send_item(1'b1, 12'h123);
    send_item(1'b1, 12'hEDC);
    // complete the first block with full-scale samples, it loads the average directly
    repeat (12) send_item(1'b0, 12'hFFF);
    drain();
    // zero threshold: anything is above hysteresis, flag clears
    set_config(16'd0, RST_GAIN, 16'd0, 8'd0);
    send_item(1'b1, 12'h000);
    send_item(1'b1, 12'hFFF);
    drain();
    // max threshold: everything is low, flag rises again
    set_config(16'hFFFF, RST_GAIN, 16'd0, 8'd0);
    send_item(1'b1, 12'h800);
    drain();

    // random phases
    set_config(16'd1650, 16'd4096, 16'd1, 8'd1);
    run_random(120, 40);
    drain();
    // max gain
    set_config(16'd30000, 16'hFFFF, 16'd2, 8'd3);
    run_random(120, 40);
    drain();

    // sender 68% idle, receiver 24% idle
    set_idling(68, 24);
    // max trip count: debounce counter has to climb all the way up
    set_config(16'hFFFF, 16'd4096, 16'd0, 8'd255);
    run_random(330, 90);
    drain();
    // zero gain and zero threshold
    set_config(16'd0, 16'd0, 16'd3, 8'd2);
    run_random(100, 40);
    drain();
    // max period, smallest gain
    set_config(16'($urandom_range(3300)), 16'd1, 16'hFFFF, 8'd1);
    run_random(60, 50);
    drain();

    // no idling at all
    set_idling(0, 0);
    random_config();
    run_random(120, 40);
    drain();
    random_config();
    fork
      run_random(120, 40);
      begin
        // long receiver hold-off while items keep coming: block backs up
        repeat (30) @(negedge clk);
        rx_hold <= 1'b1;
        repeat (400) @(negedge clk);
        rx_hold <= 1'b0;
      end
    join
    drain();

    // let any trailing activity settle
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/blm_pkg.sv
rtl/blm_front.sv
rtl/blm_queue.sv
rtl/blm_div.sv
rtl/blm_back.sv
rtl/battery_low_monitor.sv
rtl/blm_checker.sv
tb/sv/blm_result_checker.sv
tb/sv/tb_battery_low_monitor.sv
